// File: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue core.
// No dependencies; every other design file imports this package.
package spq_pkg;

	// Sizes of the entry store and of the item fields.
	localparam int DEPTH      = 16;
	localparam int KEY_W      = 32;
	localparam int TAG_W      = 8;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int KIND_W     = 3;
	localparam int COUNT_W    = 5;
	localparam int CAP_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int CAP_RESET  = 16;

	// Operation codes carried by the kind field.
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT    = 3'd0,
		KIND_REMOVE    = 3'd1,
		KIND_POP_HEAD  = 3'd2,
		KIND_POP_TAIL  = 3'd3,
		KIND_PEEK_HEAD = 3'd4,
		KIND_PEEK_TAIL = 3'd5
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SORT_ORDER = 1'b0,
		CFG_CAPACITY   = 1'b1
	} cfg_idx_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             pop_head;
		logic             order;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} spq_cmd_t;

	// Per-cell status handed to the neighbors and to the control logic.
	typedef struct packed {
		logic ins_hit;
		logic ins_seen;
		logic match;
		logic found;
	} spq_flags_t;

endpackage

// File: design/spq_cell.sv
// One storage cell of the sorted row: holds a key and a tag and shifts with its neighbors.
// Depends on spq_pkg for the command and flag structs.
module spq_cell
	import spq_pkg::*;
(
	input  logic             clk,
	input  spq_cmd_t         cmd,
	input  logic             occ,
	input  logic             left_hit,
	input  logic [KEY_W-1:0] left_key,
	input  logic [TAG_W-1:0] left_tag,
	input  logic [KEY_W-1:0] right_key,
	input  logic [TAG_W-1:0] right_tag,
	input  logic             found_in,
	output logic [KEY_W-1:0] key_q,
	output logic [TAG_W-1:0] tag_q,
	output spq_flags_t       flags
);

	logic cmp;

	// The insert point is the first cell whose key does not sort ahead of the new key.
	// An empty cell always counts as a hit, so the new entry lands at the tail otherwise.
	// left_hit is high when some cell nearer the head already holds the insert point.
	always_comb begin
		cmp            = cmd.order ? (key_q <= cmd.key) : (key_q >= cmd.key);
		flags.ins_hit  = !occ || cmp;
		flags.ins_seen = left_hit || flags.ins_hit;
		flags.match    = occ && (tag_q == cmd.tag);
		flags.found    = found_in || flags.match;
	end

	// Insert shifts toward the tail behind the insert point; removal and pop shift
	// toward the head from the removed cell onward.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_hit) begin
				key_q <= left_key;
				tag_q <= left_tag;
			end else if (flags.ins_hit) begin
				key_q <= cmd.key;
				tag_q <= cmd.tag;
			end
		end else if (cmd.pop_head || (cmd.rem && flags.found)) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end
	end

endmodule

// File: design/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a row of spq_cell instances and the control logic.
// Depends on spq_pkg and spq_cell.
//
// Usage:
// An operation (kind, key, tag) is transferred at a rising edge where start is high and
// busy is low. Busy is always low, so one operation can be transferred in every cycle.
// The result (ok, out_key, out_tag, count, full_res, empty_res) appears on the cycle
// after the transfer, marked by done for exactly one cycle; the receiver cannot stall.
// Throughput is one operation per cycle, set by one pass through the cell row: every cell
// compares its key with the broadcast key in parallel, the insert-point and tag-match
// prefixes ripple along the row, and all cells shift in the same edge.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 is sort_order (bit 0), index 1 is capacity (5 bits).
// Reset empties the queue and sets ascending order and a capacity of 16. Entry storage
// is not cleared; occupancy follows from the entry count alone, so no clearing pass runs.
module sorted_priority_queue_core
	import spq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [KIND_W-1:0]     kind,
	input  logic [KEY_W-1:0]      key,
	input  logic [TAG_W-1:0]      tag,
	output logic                  done,
	output logic                  ok,
	output logic [KEY_W-1:0]      out_key,
	output logic [TAG_W-1:0]      out_tag,
	output logic [COUNT_W-1:0]    count,
	output logic                  full_res,
	output logic                  empty_res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                 sort_order_q;
	logic [CAP_W-1:0]     capacity_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic [CNT_W-1:0]     eff_cap;

	logic [KEY_W-1:0]     cell_key [DEPTH];
	logic [TAG_W-1:0]     cell_tag [DEPTH];
	spq_flags_t           flags    [DEPTH];
	logic [DEPTH-1:0]     occ;
	logic [DEPTH-1:0]     found_in;
	logic [DEPTH-1:0]     left_hit;
	logic [KEY_W-1:0]     left_key  [DEPTH];
	logic [TAG_W-1:0]     left_tag  [DEPTH];
	logic [KEY_W-1:0]     right_key [DEPTH];
	logic [TAG_W-1:0]     right_tag [DEPTH];

	spq_cmd_t             cmd;
	logic                 any_match;
	logic                 not_empty;
	logic                 can_insert;
	logic [KEY_W-1:0]     rem_key;
	logic [TAG_W-1:0]     rem_tag;
	logic [KEY_W-1:0]     tail_key;
	logic [TAG_W-1:0]     tail_tag;
	logic                 res_ok;
	logic [KEY_W-1:0]     res_key;
	logic [TAG_W-1:0]     res_tag;
	logic                 accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_order_q <= 1'b0;
			capacity_q   <= CAP_W'(CAP_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SORT_ORDER: sort_order_q <= cfg_data[0];
				CFG_CAPACITY:   capacity_q   <= cfg_data[CAP_W-1:0];
				default:        ;
			endcase
		end
	end

	// Capacity saturates at the store depth.
	always_comb begin
		if (int'(capacity_q) > DEPTH) begin
			eff_cap = CNT_W'(DEPTH);
		end else begin
			eff_cap = CNT_W'(capacity_q);
		end
	end

	// Occupied cells form a prefix of the row given by the entry count.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = (count_q > CNT_W'(i));
		end
	end

	// Neighbor wiring of the row; the ends see empty neighbors.
	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign left_hit[g] = 1'b0;
				assign left_key[g] = '0;
				assign left_tag[g] = '0;
				assign found_in[g] = 1'b0;
			end else begin : g_link
				assign left_hit[g] = flags[g-1].ins_seen;
				assign left_key[g] = cell_key[g-1];
				assign left_tag[g] = cell_tag[g-1];
				assign found_in[g] = flags[g-1].found;
			end
			if (g == DEPTH - 1) begin : g_tail
				assign right_key[g] = '0;
				assign right_tag[g] = '0;
			end else begin : g_next
				assign right_key[g] = cell_key[g+1];
				assign right_tag[g] = cell_tag[g+1];
			end

			spq_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.occ       (occ[g]),
				.left_hit  (left_hit[g]),
				.left_key  (left_key[g]),
				.left_tag  (left_tag[g]),
				.right_key (right_key[g]),
				.right_tag (right_tag[g]),
				.found_in  (found_in[g]),
				.key_q     (cell_key[g]),
				.tag_q     (cell_tag[g]),
				.flags     (flags[g])
			);
		end
	endgenerate

	// Select the first tag match and the tail entry by one-hot OR over the row.
	always_comb begin
		rem_key  = '0;
		rem_tag  = '0;
		tail_key = '0;
		tail_tag = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (flags[i].match && !found_in[i]) begin
				rem_key = rem_key | cell_key[i];
				rem_tag = rem_tag | cell_tag[i];
			end
			if (count_q == CNT_W'(i + 1)) begin
				tail_key = tail_key | cell_key[i];
				tail_tag = tail_tag | cell_tag[i];
			end
		end
	end

	// Decode the operation into the row command, the result and the next count.
	always_comb begin
		any_match  = flags[DEPTH-1].found;
		not_empty  = (count_q != '0);
		can_insert = (count_q < eff_cap);

		cmd.ins      = 1'b0;
		cmd.rem      = 1'b0;
		cmd.pop_head = 1'b0;
		cmd.order    = sort_order_q;
		cmd.key      = key;
		cmd.tag      = tag;

		res_ok    = 1'b0;
		res_key   = '0;
		res_tag   = '0;
		count_nxt = count_q;

		unique case (kind_t'(kind)) inside
			KIND_INSERT: begin
				if (can_insert) begin
					cmd.ins   = accept;
					res_ok    = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			KIND_REMOVE: begin
				if (any_match) begin
					cmd.rem   = accept;
					res_ok    = 1'b1;
					res_key   = rem_key;
					res_tag   = rem_tag;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			KIND_POP_HEAD, KIND_PEEK_HEAD: begin
				if (not_empty) begin
					res_ok  = 1'b1;
					res_key = cell_key[0];
					res_tag = cell_tag[0];
					if (kind_t'(kind) == KIND_POP_HEAD) begin
						cmd.pop_head = accept;
						count_nxt    = count_q - CNT_W'(1);
					end
				end
			end
			KIND_POP_TAIL, KIND_PEEK_TAIL: begin
				if (not_empty) begin
					res_ok  = 1'b1;
					res_key = tail_key;
					res_tag = tail_tag;
					if (kind_t'(kind) == KIND_POP_TAIL) begin
						count_nxt = count_q - CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Entry count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	// Result registers hold the outcome of the most recently transferred operation.
	always_ff @(posedge clk) begin
		if (accept) begin
			ok        <= res_ok;
			out_key   <= res_key;
			out_tag   <= res_tag;
			count     <= COUNT_W'(count_nxt);
			full_res  <= (count_nxt >= eff_cap);
			empty_res <= (count_nxt == '0);
		end
	end

	// Every transferred operation gives exactly one result in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result strobe missing after an operation transfer");

	// A refused operation leaves the entry count as it was.
	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> count_q == $past(count_q))
		else $error("failed operation changed the entry count");

	// A successful insert grows the queue by exactly one entry.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_INSERT && can_insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not add one entry");

	// The entry count never exceeds the store depth, and ok matches the decoded result.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> int'(count_q) <= DEPTH && ok == $past(res_ok))
		else $error("entry count out of range or result mismatch");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for sorted_priority_queue_core: directed, capacity and random tests.
// Depends on spq_pkg and the design files; keeps its own model of the sorted (key, tag) store.
module testbench;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The kind field has two spare codes that the block must answer with ok low.
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam logic [KEY_W-1:0]  KEY_MAX       = '1;
	localparam logic [TAG_W-1:0]  TAG_MAX       = '1;

	// One expected answer of the queue.
	typedef struct packed {
		logic               ok;
		logic [KEY_W-1:0]   key;
		logic [TAG_W-1:0]   tag;
		logic [COUNT_W-1:0] cnt;
		logic               full;
		logic               empty;
	} queue_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [KIND_W-1:0]     kind = '0;
	logic [KEY_W-1:0]      key = '0;
	logic [TAG_W-1:0]      tag = '0;
	logic                  done;
	logic                  ok;
	logic [KEY_W-1:0]      out_key;
	logic [TAG_W-1:0]      out_tag;
	logic [COUNT_W-1:0]    count;
	logic                  full_res;
	logic                  empty_res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Model of the queue contents and of the two registers.
	logic [KEY_W-1:0]  model_keys [DEPTH];
	logic [TAG_W-1:0]  model_tags [DEPTH];
	int                model_count = 0;
	logic              model_desc = 1'b0;
	logic [CAP_W-1:0]  model_cap = CAP_W'(CAP_RESET);

	queue_result_t     pending_results [$];
	int                error_count = 0;

	sorted_priority_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.key       (key),
		.tag       (tag),
		.done      (done),
		.ok        (ok),
		.out_key   (out_key),
		.out_tag   (out_tag),
		.count     (count),
		.full_res  (full_res),
		.empty_res (empty_res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard limit on the run, far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Close the gap left by removing the entry at pos.
	function automatic void model_take_out(input int pos);
		for (int i = pos; i + 1 < model_count; i++) begin
			model_keys[i] = model_keys[i + 1];
			model_tags[i] = model_tags[i + 1];
		end
		model_count--;
	endfunction

	// Apply one operation to the model and return the answer the block should give.
	function automatic queue_result_t predict_queue_op(input logic [KIND_W-1:0] op,
			input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t);
		queue_result_t r;
		int            pos;
		int            limit;
		r = '0;
		limit = (model_cap > DEPTH) ? DEPTH : int'(model_cap);
		case (op)
			KIND_INSERT: begin
				if (model_count < limit) begin
					pos = model_count;
					for (int i = 0; i < model_count; i++) begin
						if (model_desc ? (model_keys[i] <= k) : (model_keys[i] >= k)) begin
							pos = i;
							break;
						end
					end
					for (int i = model_count; i > pos; i--) begin
						model_keys[i] = model_keys[i - 1];
						model_tags[i] = model_tags[i - 1];
					end
					model_keys[pos] = k;
					model_tags[pos] = t;
					model_count++;
					r.ok = 1'b1;
				end
			end
			KIND_REMOVE: begin
				for (int i = 0; i < model_count; i++) begin
					if (model_tags[i] == t) begin
						r.key = model_keys[i];
						r.tag = model_tags[i];
						r.ok = 1'b1;
						model_take_out(i);
						break;
					end
				end
			end
			KIND_POP_HEAD, KIND_POP_TAIL, KIND_PEEK_HEAD, KIND_PEEK_TAIL: begin
				if (model_count > 0) begin
					pos = (op == KIND_POP_HEAD || op == KIND_PEEK_HEAD) ? 0 : model_count - 1;
					r.key = model_keys[pos];
					r.tag = model_tags[pos];
					r.ok = 1'b1;
					if (op == KIND_POP_HEAD || op == KIND_POP_TAIL)
						model_take_out(pos);
				end
			end
			default: ;
		endcase
		r.cnt = model_count[COUNT_W-1:0];
		r.full = (model_count >= limit);
		r.empty = (model_count == 0);
		return r;
	endfunction

	// Offer one operation and wait for its transfer; start stays high for the caller.
	task automatic send_op(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [TAG_W-1:0] t);
		start <= 1'b1;
		kind <= op;
		key <= k;
		tag <= t;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_results.push_back(predict_queue_op(op, k, t));
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 16)) @(posedge clk);
	endtask

	// Hold the sender until every result has come, then let the single stage settle.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Register write; only called while the queue is idle.
	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		if (idx == CFG_SORT_ORDER)
			model_desc = value[0];
		else
			model_cap = value[CAP_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string field, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
	endtask

	// Every result is compared with the oldest prediction.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no operation pending");
			end else begin
				want = pending_results.pop_front();
				check_field("ok", KEY_W'(ok), KEY_W'(want.ok));
				check_field("out_key", out_key, want.key);
				check_field("out_tag", KEY_W'(out_tag), KEY_W'(want.tag));
				check_field("count", KEY_W'(count), KEY_W'(want.cnt));
				check_field("full_res", KEY_W'(full_res), KEY_W'(want.full));
				check_field("empty_res", KEY_W'(empty_res), KEY_W'(want.empty));
			end
		end
	end

	// Empty queue answers, spare codes, extreme keys and tags, ties in both orders.
	task automatic test_directed();
		send_op(KIND_POP_HEAD, '0, '0);
		send_op(KIND_POP_TAIL, '0, '0);
		send_op(KIND_PEEK_HEAD, '0, '0);
		send_op(KIND_PEEK_TAIL, '0, '0);
		send_op(KIND_REMOVE, '0, '0);
		send_op(KIND_SPARE_LO, KEY_MAX, TAG_MAX);
		send_op(KIND_SPARE_HI, KEY_MAX, TAG_MAX);
		send_op(KIND_INSERT, 32'd5, 8'h01);
		send_op(KIND_INSERT, KEY_MAX, TAG_MAX);
		send_op(KIND_INSERT, '0, '0);
		// An equal key goes ahead of the stored one.
		send_op(KIND_INSERT, 32'd5, 8'h80);
		send_op(KIND_INSERT, 32'hA5A5_A5A5, 8'h5A);
		send_op(KIND_PEEK_HEAD, '0, '0);
		send_op(KIND_PEEK_TAIL, '0, '0);
		send_op(KIND_REMOVE, '0, 8'h80);
		send_op(KIND_REMOVE, '0, 8'h33);
		send_op(KIND_INSERT, 32'd5, 8'h7F);
		send_op(KIND_POP_TAIL, '0, '0);
		send_op(KIND_POP_HEAD, '0, '0);
		send_op(KIND_SPARE_HI, 32'h1234_5678, 8'h01);
		drain_results();
		write_register(CFG_SORT_ORDER, 5'd1);
		send_op(KIND_INSERT, 32'd5, 8'h11);
		send_op(KIND_INSERT, 32'd5, 8'h22);
		send_op(KIND_INSERT, KEY_MAX, 8'h33);
		send_op(KIND_INSERT, '0, 8'h44);
		send_op(KIND_PEEK_HEAD, '0, '0);
		send_op(KIND_POP_TAIL, '0, '0);
		drain_results();
	endtask

	// Capacity of one, zero, beyond the store, and lowered below the count.
	task automatic test_capacity();
		write_register(CFG_SORT_ORDER, 5'd0);
		while (model_count > 0)
			send_op(KIND_POP_HEAD, '0, '0);
		drain_results();
		write_register(CFG_CAPACITY, 5'd1);
		send_op(KIND_INSERT, 32'd100, 8'h01);
		send_op(KIND_INSERT, 32'd50, 8'h02);
		drain_results();
		write_register(CFG_CAPACITY, 5'd0);
		send_op(KIND_INSERT, 32'd7, 8'h03);
		send_op(KIND_POP_HEAD, '0, '0);
		send_op(KIND_INSERT, 32'd7, 8'h03);
		drain_results();
		write_register(CFG_CAPACITY, 5'd31);
		for (int i = 0; i < DEPTH + 1; i++)
			send_op(KIND_INSERT, $urandom_range(0, 20), TAG_W'(i));
		drain_results();
		write_register(CFG_CAPACITY, 5'd3);
		send_op(KIND_INSERT, 32'd1, 8'hEE);
		send_op(KIND_POP_TAIL, '0, '0);
		send_op(KIND_PEEK_HEAD, '0, '0);
		drain_results();
		write_register(CFG_CAPACITY, 5'd16);
		send_op(KIND_INSERT, 32'd1, 8'hEE);
		send_op(KIND_INSERT, 32'd2, 8'hEF);
		drain_results();
	endtask

	// Mostly meaningful traffic: inserts with tied and extreme keys, removes of stored tags.
	task automatic test_random_traffic(input int n_ops, input bit allow_idle);
		logic [KIND_W-1:0] op;
		logic [KEY_W-1:0]  k;
		logic [TAG_W-1:0]  t;
		int                pick;
		int                idle_rate;
		idle_rate = 0;
		for (int n = 0; n < n_ops; n++) begin
			// Change the idling density now and then, including stretches without it.
			if (n % 30 == 0)
				idle_rate = allow_idle ? $urandom_range(0, 2) : 0;
			pick = $urandom_range(0, 99);
			if (pick < 45)
				op = KIND_INSERT;
			else if (pick < 60)
				op = KIND_REMOVE;
			else if (pick < 70)
				op = KIND_POP_HEAD;
			else if (pick < 80)
				op = KIND_POP_TAIL;
			else if (pick < 88)
				op = KIND_PEEK_HEAD;
			else if (pick < 96)
				op = KIND_PEEK_TAIL;
			else
				op = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
			case ($urandom_range(0, 3))
				0: k = $urandom_range(0, 7);
				1: k = $urandom_range(0, 1) ? KEY_MAX : '0;
				default: k = $urandom;
			endcase
			t = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom_range(0, 255))
					: TAG_W'($urandom_range(0, 15));
			// Removes usually name a stored tag.
			if (op == KIND_REMOVE && model_count > 0 && $urandom_range(0, 3) != 0)
				t = model_tags[$urandom_range(0, model_count - 1)];
			send_op(op, k, t);
			if (idle_rate != 0 && $urandom_range(0, 4 - idle_rate) == 0)
				idle_burst();
			if (allow_idle && $urandom_range(0, 59) == 0)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity();
		test_random_traffic(100, 1'b1);
		write_register(CFG_SORT_ORDER, 5'd1);
		write_register(CFG_CAPACITY, CFG_DATA_W'($urandom_range(4, 15)));
		test_random_traffic(90, 1'b1);
		write_register(CFG_SORT_ORDER, 5'd0);
		write_register(CFG_CAPACITY, 5'd1);
		test_random_traffic(40, 1'b1);
		write_register(CFG_SORT_ORDER, 5'd1);
		write_register(CFG_CAPACITY, 5'd16);
		test_random_traffic(100, 1'b1);
		// Closing part runs back to back with no idling.
		write_register(CFG_SORT_ORDER, 5'd0);
		write_register(CFG_CAPACITY, 5'd8);
		test_random_traffic(80, 1'b0);
		drain_results();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
